/* sv/ssc_pkg.sv */
// ----------------------------------------------------------------------------
// ssc_pkg
// Shared constants and controller/datapath interface types for the step clock.
// ----------------------------------------------------------------------------
package ssc_pkg;

    // Bar, step and fixed-point geometry
    localparam int STEPS_PER_BAR  = 16;
    localparam int STEP_W         = $clog2(STEPS_PER_BAR);
    localparam int OUT_STEP_W     = 4;
    localparam int WAIT_FRAC_BITS = 8;

    // Field widths
    localparam int SR_W      = 18;
    localparam int TEMPO_W   = 14;
    localparam int SHUFFLE_W = 8;

    // Sample counter and wait
    localparam int COUNT_W = 17;
    localparam int WAIT_W  = COUNT_W + WAIT_FRAC_BITS;
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic [WAIT_W-1:0]  WAIT_MAX  = {COUNT_MAX, {WAIT_FRAC_BITS{1'b0}}};
    localparam logic [WAIT_W-1:0]  WAIT_RESET = WAIT_W'(1) << WAIT_FRAC_BITS;

    // Tempo and swing constants
    localparam int MIN_TEMPO      = 640;  // 40 bpm in sixteenth units
    localparam int MIN_TEMPO_LOG2 = 9;    // 2^9 <= MIN_TEMPO
    localparam int SR_SCALE       = 240;  // 15 s/min * 16 units per beat
    localparam int SR_SCALE_W     = 8;
    localparam int SHUFFLE_MAX    = 179;  // 0.7 in 1/256
    localparam int SWING_SHIFT    = 9;    // /256 and /2

    // Divider geometry
    localparam int NUM_W  = SR_W + SR_SCALE_W + WAIT_FRAC_BITS;
    localparam int SIXT_W = NUM_W - MIN_TEMPO_LOG2;
    localparam int DIV_CNT_W = $clog2(NUM_W + 1);
    localparam int PROD_W = SHUFFLE_W + SIXT_W;

    localparam logic [SR_W-1:0] SR_RESET = SR_W'(48000);

    typedef struct packed {
        logic capture;      // latch the input word
        logic eval_restart; // transport reset
        logic eval_first;   // first tick: fire step 0 with zero wait
        logic eval_count;   // plain count, no step
        logic eval_fire;    // advance step, start sixteenth division
        logic mul_swing;    // register shuffle * sixteenth
        logic apply_wait;   // form new wait, mark result as fired
        logic load_out;     // move result into the output register
    } ssc_cmd_t;

    typedef struct packed {
        logic restart;
        logic running;
        logic below_wait;
        logic div_done;
        logic out_free;
    } ssc_status_t;

endpackage

/* sv/ssc_div.sv */
// ----------------------------------------------------------------------------
// ssc_div
// Restoring divider, one quotient bit per cycle, for the sixteenth length.
// ----------------------------------------------------------------------------
module ssc_div
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [ssc_pkg::NUM_W-1:0]     dividend,
    input  logic [ssc_pkg::TEMPO_W-1:0]   divisor,
    output logic                          done,
    output logic [ssc_pkg::SIXT_W-1:0]    quotient
);
    import ssc_pkg::*;

    logic [NUM_W-1:0]     dvd_reg, dvd_next;
    logic [TEMPO_W-1:0]   rem_reg, rem_next;
    logic [TEMPO_W-1:0]   den_reg, den_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [TEMPO_W:0]     trial;
    logic                 take;

    assign trial = {rem_reg, dvd_reg[NUM_W-1]};
    assign take  = trial >= {1'b0, den_reg};

    always_comb
    begin
        dvd_next = dvd_reg;
        rem_next = rem_reg;
        den_next = den_reg;
        cnt_next = cnt_reg;
        if (start)
        begin
            dvd_next = dividend;
            rem_next = '0;
            den_next = divisor;
            cnt_next = DIV_CNT_W'(NUM_W);
        end
        else if (cnt_reg != '0)
        begin
            // shift in the next quotient bit, keep the partial remainder
            dvd_next = {dvd_reg[NUM_W-2:0], take};
            rem_next = take ? TEMPO_W'(trial - {1'b0, den_reg}) : TEMPO_W'(trial);
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done     = (cnt_reg == '0) && !start;
    assign quotient = dvd_reg[SIXT_W-1:0];

endmodule

/* sv/ssc_ctrl.sv */
// ----------------------------------------------------------------------------
// ssc_ctrl
// Sequencer for one tick: accept, evaluate, then divide, swing and apply on a step, send.
// ----------------------------------------------------------------------------
module ssc_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  ssc_pkg::ssc_status_t  status,
    output ssc_pkg::ssc_cmd_t     cmd
);
    import ssc_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EVAL  = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_SWING = 3'd3;
    localparam logic [2:0] S_APPLY = 3'd4;
    localparam logic [2:0] S_SEND  = 3'd5;

    logic [2:0] state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
                if (in_valid)
                    state_next = S_EVAL;
            end
            S_EVAL:
            begin
                if (status.restart)
                begin
                    cmd.eval_restart = 1'b1;
                    state_next       = S_SEND;
                end
                else if (!status.running)
                begin
                    cmd.eval_first = 1'b1;
                    state_next     = S_SEND;
                end
                else if (status.below_wait)
                begin
                    cmd.eval_count = 1'b1;
                    state_next     = S_SEND;
                end
                else
                begin
                    cmd.eval_fire = 1'b1;
                    state_next    = S_DIV;
                end
            end
            S_DIV:
            begin
                if (status.div_done)
                    state_next = S_SWING;
            end
            S_SWING:
            begin
                cmd.mul_swing = 1'b1;
                state_next    = S_APPLY;
            end
            S_APPLY:
            begin
                cmd.apply_wait = 1'b1;
                state_next     = S_SEND;
            end
            S_SEND:
            begin
                // hold the result until the output register frees up
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    a_idle_div_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> status.div_done)
        else $error("divider busy while idle");

    a_fire_to_div: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.eval_fire |=> (state_reg == S_DIV) && !status.div_done)
        else $error("division not started on a step");

    a_send_after_apply: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.apply_wait |=> (state_reg == S_SEND))
        else $error("apply not followed by send");

endmodule

/* sv/ssc_datapath.sv */
// ----------------------------------------------------------------------------
// ssc_datapath
// Transport state, sample counter, wait arithmetic and output register.
// ----------------------------------------------------------------------------
module ssc_datapath
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  ssc_pkg::ssc_cmd_t               cmd,
    output ssc_pkg::ssc_status_t            status,
    input  logic                            cfg_wr_en,
    input  logic [ssc_pkg::SR_W-1:0]        cfg_wr_data,
    input  logic [ssc_pkg::TEMPO_W-1:0]     tempo_sixteenths_bpm,
    input  logic [ssc_pkg::SHUFFLE_W-1:0]   shuffle_amount,
    input  logic                            restart,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            fired,
    output logic [ssc_pkg::OUT_STEP_W-1:0]  step_index
);
    import ssc_pkg::*;

    // transport state
    logic [SR_W-1:0]    sample_rate_reg;
    logic               running_reg, running_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [WAIT_W-1:0]  wait_reg, wait_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic               out_valid_reg;

    // input word and working values
    logic [TEMPO_W-1:0]   tempo_reg;
    logic [SHUFFLE_W-1:0] shuffle_reg;
    logic                 restart_reg;
    logic                 pend_fired_reg, pend_fired_next;
    logic [PROD_W-1:0]    prod_reg;
    logic                 fired_reg;
    logic [OUT_STEP_W-1:0] step_out_reg;

    logic [COUNT_W-1:0]   count_inc;
    logic                 below_wait;
    logic [NUM_W-1:0]     numerator;
    logic [TEMPO_W-1:0]   divisor;
    logic                 div_done;
    logic [SIXT_W-1:0]    sixteenth;
    logic [SHUFFLE_W-1:0] shuffle_clamped;
    logic [SIXT_W:0]      swing;
    logic [SIXT_W:0]      wait_raw;
    logic [STEP_W-1:0]    step_adv;

    assign count_inc  = (count_reg < COUNT_MAX) ? count_reg + 1'b1 : count_reg;
    assign below_wait = {count_inc, {WAIT_FRAC_BITS{1'b0}}} < wait_reg;

    assign numerator = (NUM_W'(sample_rate_reg) * NUM_W'(SR_SCALE)) << WAIT_FRAC_BITS;
    assign divisor   = (tempo_reg < TEMPO_W'(MIN_TEMPO)) ? TEMPO_W'(MIN_TEMPO) : tempo_reg;

    ssc_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.eval_fire),
        .dividend (numerator),
        .divisor  (divisor),
        .done     (div_done),
        .quotient (sixteenth)
    );

    assign shuffle_clamped = (shuffle_reg > SHUFFLE_W'(SHUFFLE_MAX)) ?
                             SHUFFLE_W'(SHUFFLE_MAX) : shuffle_reg;
    assign swing    = (SIXT_W+1)'(prod_reg >> SWING_SHIFT);
    // odd steps stretch, even steps shrink
    assign wait_raw = step_reg[0] ? {1'b0, sixteenth} + swing : {1'b0, sixteenth} - swing;

    assign step_adv = (step_reg == STEP_W'(STEPS_PER_BAR - 1)) ? '0 : step_reg + 1'b1;

    always_comb
    begin
        running_next    = running_reg;
        count_next      = count_reg;
        wait_next       = wait_reg;
        step_next       = step_reg;
        pend_fired_next = pend_fired_reg;
        if (cmd.eval_restart)
        begin
            running_next    = 1'b0;
            count_next      = '0;
            wait_next       = WAIT_RESET;
            step_next       = '0;
            pend_fired_next = 1'b0;
        end
        else if (cmd.eval_first)
        begin
            running_next    = 1'b1;
            count_next      = '0;
            wait_next       = '0;
            step_next       = '0;
            pend_fired_next = 1'b1;
        end
        else if (cmd.eval_count)
        begin
            count_next      = count_inc;
            pend_fired_next = 1'b0;
        end
        else if (cmd.eval_fire)
        begin
            count_next = '0;
            step_next  = step_adv;
        end
        else if (cmd.apply_wait)
        begin
            wait_next       = (wait_raw > (SIXT_W+1)'(WAIT_MAX)) ? WAIT_MAX : WAIT_W'(wait_raw);
            pend_fired_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_rate_reg <= SR_RESET;
            running_reg     <= 1'b0;
            count_reg       <= '0;
            wait_reg        <= WAIT_RESET;
            step_reg        <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                sample_rate_reg <= cfg_wr_data;
            running_reg <= running_next;
            count_reg   <= count_next;
            wait_reg    <= wait_next;
            step_reg    <= step_next;
            if (cmd.load_out)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_fired_reg <= pend_fired_next;
        if (cmd.capture)
        begin
            tempo_reg   <= tempo_sixteenths_bpm;
            shuffle_reg <= shuffle_amount;
            restart_reg <= restart;
        end
        if (cmd.mul_swing)
            prod_reg <= PROD_W'(shuffle_clamped) * PROD_W'(sixteenth);
        if (cmd.load_out)
        begin
            fired_reg    <= pend_fired_reg;
            step_out_reg <= OUT_STEP_W'(step_reg);
        end
    end

    always_comb
    begin
        status            = '0;
        status.restart    = restart_reg;
        status.running    = running_reg;
        status.below_wait = below_wait;
        status.div_done   = div_done;
        status.out_free   = !out_valid_reg || out_ready;
    end

    assign out_valid  = out_valid_reg;
    assign fired      = fired_reg;
    assign step_index = step_out_reg;

    a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.eval_restart |=> !running_reg && (count_reg == '0) && (step_reg == '0))
        else $error("restart left transport state behind");

    a_wait_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.apply_wait |=> (wait_reg <= WAIT_MAX))
        else $error("wait exceeds counter reach");

    a_step_in_bar: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg <= STEP_W'(STEPS_PER_BAR - 1))
        else $error("step index outside bar");

    a_fire_needs_run: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_out && pend_fired_reg) |-> running_reg)
        else $error("step fired while stopped");

endmodule

/* sv/swing_step_clock.sv */
// ----------------------------------------------------------------------------
// swing_step_clock
// Sixteenth-note step clock with swing, one word per audio sample.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): one word per audio sample carrying the
// tempo in sixteenth-bpm units, the shuffle amount and a transport restart.
// Output channel (out_valid/out_ready): one word per input word, carrying
// fired (a new step began) and the current step index.
// cfg_wr_en/cfg_wr_data write the sample rate; write only while idle.
// Sequence: a word that does not start a step goes from accept through the
// evaluate state to the send state; a word that starts a step also passes
// the restoring divider that forms the sixteenth length, one quotient bit per
// cycle, then a multiply for the swing and the apply state for the wait.
// One word is in flight at a time; in_ready rises again once the result
// has moved into the output register, so a new word is taken only after
// the last one is through.
// Reset clears the transport (stopped, step 0) and loads 48000 samples/s.
// A restart word clears the transport in the same way and keeps the rate.
// If the receiver stalls, the result waits in the output register; one
// further word may be accepted and is held finished until the register frees.
// ----------------------------------------------------------------------------
module swing_step_clock
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [ssc_pkg::SR_W-1:0]        cfg_wr_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [ssc_pkg::TEMPO_W-1:0]     tempo_sixteenths_bpm,
    input  logic [ssc_pkg::SHUFFLE_W-1:0]   shuffle_amount,
    input  logic                            restart,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            fired,
    output logic [ssc_pkg::OUT_STEP_W-1:0]  step_index
);
    import ssc_pkg::*;

    ssc_cmd_t    cmd;
    ssc_status_t status;

    ssc_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    ssc_datapath u_datapath
    (
        .clk                  (clk),
        .rst_n                (rst_n),
        .cmd                  (cmd),
        .status               (status),
        .cfg_wr_en            (cfg_wr_en),
        .cfg_wr_data          (cfg_wr_data),
        .tempo_sixteenths_bpm (tempo_sixteenths_bpm),
        .shuffle_amount       (shuffle_amount),
        .restart              (restart),
        .out_valid            (out_valid),
        .out_ready            (out_ready),
        .fired                (fired),
        .step_index           (step_index)
    );

endmodule
